// File: rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// shared types, phase codes and crc-16/arc byte update for the frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_HDR2    = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRCLO   = 6'b010000,
    PH_CRCHI   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic        version_bit;
    logic [6:0]  flag_bits;
    logic [7:0]  frame_id;
    logic [7:0]  payload_length;
    logic [15:0] received_crc;
    logic        crc_ok;
    logic        last;
  } res_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pfd_parser.sv
// ----------------------------------------------------------------------------
// pfd_parser
// input byte register, frame parse state, running crc and result forming
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,
  output logic               res_valid,
  output pfd_pkg::res_t      res,
  input  wire logic          res_ready
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             has_result;
  logic             advance;

  pfd_pkg::phase_t  phase, phase_next;
  logic [15:0]      crc, crc_next;
  logic             held_version, held_version_next;
  logic [6:0]       held_flags, held_flags_next;
  logic [7:0]       held_id, held_id_next;
  logic [7:0]       held_length, held_length_next;
  logic [7:0]       count, count_next;
  logic [7:0]       crc_lo, crc_lo_next;
  logic [7:0]       count_inc;

  assign count_inc     = count + 8'd1;
  assign advance       = in_valid && (!has_result || res_ready);
  assign s_axis_tready = !in_valid || advance;
  assign res_valid     = in_valid && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_comb begin
    phase_next        = phase;
    crc_next          = crc;
    held_version_next = held_version;
    held_flags_next   = held_flags;
    held_id_next      = held_id;
    held_length_next  = held_length;
    count_next        = count;
    crc_lo_next       = crc_lo;
    has_result        = 1'b0;
    res               = '0;
    res.version_bit    = held_version;
    res.flag_bits      = held_flags;
    res.frame_id       = held_id;
    res.payload_length = held_length;
    unique case (phase)
      pfd_pkg::PH_HDR1: begin
        held_id_next = in_byte;
        crc_next     = pfd_pkg::crc_add_byte(crc, in_byte);
        phase_next   = pfd_pkg::PH_HDR2;
      end
      pfd_pkg::PH_HDR2: begin
        held_length_next = in_byte;
        count_next       = '0;
        crc_next         = pfd_pkg::crc_add_byte(crc, in_byte);
        phase_next       = (in_byte == 8'd0) ? pfd_pkg::PH_CRCLO : pfd_pkg::PH_PAYLOAD;
      end
      pfd_pkg::PH_PAYLOAD: begin
        has_result       = 1'b1;
        res.kind         = pfd_pkg::KIND_PAYLOAD;
        res.payload_byte = in_byte;
        res.byte_index   = count;
        crc_next         = pfd_pkg::crc_add_byte(crc, in_byte);
        count_next       = count_inc;
        if (count_inc == held_length) begin
          phase_next = pfd_pkg::PH_CRCLO;
        end
      end
      pfd_pkg::PH_CRCLO: begin
        crc_lo_next = in_byte;
        phase_next  = pfd_pkg::PH_CRCHI;
      end
      pfd_pkg::PH_CRCHI: begin
        has_result       = 1'b1;
        res.kind         = pfd_pkg::KIND_FRAME_END;
        res.received_crc = {in_byte, crc_lo};
        res.crc_ok       = ({in_byte, crc_lo} == crc);
        res.last         = 1'b1;
        crc_next         = '0;
        phase_next       = pfd_pkg::PH_HDR0;
      end
      default: begin
        held_version_next = in_byte[7];
        held_flags_next   = in_byte[6:0];
        crc_next          = pfd_pkg::crc_add_byte(16'h0000, in_byte);
        phase_next        = pfd_pkg::PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pfd_pkg::PH_HDR0;
      crc          <= '0;
      held_version <= 1'b0;
      held_flags   <= '0;
      held_id      <= '0;
      held_length  <= '0;
      count        <= '0;
      crc_lo       <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      crc          <= crc_next;
      held_version <= held_version_next;
      held_flags   <= held_flags_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
      count        <= count_next;
      crc_lo       <= crc_lo_next;
    end
  end

`ifndef SYNTH
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("parse phase not one-hot");
  a_frame_end_restart: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> (phase == pfd_pkg::PH_HDR0 && crc == 16'h0000))
    else $error("frame end did not restart parser");
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == pfd_pkg::PH_PAYLOAD) |-> (count < held_length))
    else $error("payload count beyond length");
`endif

endmodule

`default_nettype wire

// File: rtl/pfd_out_reg.sv
// ----------------------------------------------------------------------------
// pfd_out_reg
// result register and output stream packing
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_valid,
  input  wire pfd_pkg::res_t res,
  output logic               res_ready,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  pfd_pkg::res_t held;

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {7'b0, held.crc_ok, held.received_crc, held.payload_length,
                         held.frame_id, held.flag_bits, held.version_bit,
                         held.byte_index, held.payload_byte};
  assign m_axis_tuser = held.kind;
  assign m_axis_tlast = held.last;

endmodule

`default_nettype wire

// File: rtl/packet_frame_decoder_crc16.sv
// latency: an accepted byte is held in the input register, and its result moves on
// into the output register once that register can take it; only then is it presented
// throughput: one byte per cycle with a bytewise crc update, unless output stalls a result
// reset: synchronous rst returns the parser to header byte zero with crc zero
// and empties the input and output registers
// ----------------------------------------------------------------------------
// packet_frame_decoder_crc16
// byte stream frame deframer with crc-16/arc check
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_decoder_crc16 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // payload_byte, byte_index, version_bit, flag_bits, frame_id,
  // payload_length, received_crc, crc_ok
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast
);

  logic          res_valid;
  logic          res_ready;
  pfd_pkg::res_t res;

  pfd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  pfd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: sim/pfd_checker.sv
// ----------------------------------------------------------------------------
// pfd_checker
// Watches both stream channels of the frame decoder. Each accepted input byte
// goes through a local frame parser with its own crc-16/arc state, which queues
// the payload and frame end results that the byte should cause. Each accepted
// output transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module pfd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          error_count,
  output int          results_owed
);

  timeunit 1ns;
  timeprecision 1ps;

  // parser state
  pfd_pkg::phase_t phase;
  logic [15:0]     crc_acc;
  logic            hdr_version;
  logic [6:0]      hdr_flags;
  logic [7:0]      hdr_id;
  logic [7:0]      hdr_length;
  logic [7:0]      payload_seen;
  logic [7:0]      crc_lo_held;

  pfd_pkg::res_t   decoded_results[$];
  pfd_pkg::res_t   got;
  pfd_pkg::res_t   want;
  pfd_pkg::res_t   next_res;
  bit              has_res;
  string           bad_fields;
  int              shown = 0;

  function automatic logic [15:0] crc_arc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ pfd_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_parser();
    phase        = pfd_pkg::PH_HDR0;
    crc_acc      = 16'h0000;
    hdr_version  = 1'b0;
    hdr_flags    = 7'h00;
    hdr_id       = 8'h00;
    hdr_length   = 8'h00;
    payload_seen = 8'h00;
    crc_lo_held  = 8'h00;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, output bit has, output pfd_pkg::res_t r);
    r   = '0;
    has = 1'b0;
    case (phase)
      pfd_pkg::PH_HDR1: begin
        hdr_id  = b;
        crc_acc = crc_arc_step(crc_acc, b);
        phase   = pfd_pkg::PH_HDR2;
      end
      pfd_pkg::PH_HDR2: begin
        hdr_length   = b;
        payload_seen = 8'h00;
        crc_acc      = crc_arc_step(crc_acc, b);
        phase        = (b == 8'h00) ? pfd_pkg::PH_CRCLO : pfd_pkg::PH_PAYLOAD;
      end
      pfd_pkg::PH_PAYLOAD: begin
        has              = 1'b1;
        r.kind           = pfd_pkg::KIND_PAYLOAD;
        r.payload_byte   = b;
        r.byte_index     = payload_seen;
        r.version_bit    = hdr_version;
        r.flag_bits      = hdr_flags;
        r.frame_id       = hdr_id;
        r.payload_length = hdr_length;
        crc_acc          = crc_arc_step(crc_acc, b);
        payload_seen     = payload_seen + 8'd1;
        if (payload_seen == hdr_length) begin
          phase = pfd_pkg::PH_CRCLO;
        end
      end
      pfd_pkg::PH_CRCLO: begin
        crc_lo_held = b;
        phase       = pfd_pkg::PH_CRCHI;
      end
      pfd_pkg::PH_CRCHI: begin
        has              = 1'b1;
        r.kind           = pfd_pkg::KIND_FRAME_END;
        r.version_bit    = hdr_version;
        r.flag_bits      = hdr_flags;
        r.frame_id       = hdr_id;
        r.payload_length = hdr_length;
        r.received_crc   = {b, crc_lo_held};
        r.crc_ok         = ({b, crc_lo_held} == crc_acc);
        r.last           = 1'b1;
        crc_acc          = 16'h0000;
        phase            = pfd_pkg::PH_HDR0;
      end
      default: begin
        hdr_version = b[7];
        hdr_flags   = b[6:0];
        crc_acc     = crc_arc_step(16'h0000, b);
        phase       = pfd_pkg::PH_HDR1;
      end
    endcase
  endtask

  task automatic check_transfer(input pfd_pkg::res_t r);
    if (decoded_results.size() == 0) begin
      error_count++;
      if (shown < 10) begin
        shown++;
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0d", $realtime, r.kind,
                 r.payload_byte, r.last);
      end
      return;
    end
    want       = decoded_results.pop_front();
    bad_fields = "";
    if (r.kind !== want.kind)                     bad_fields = {bad_fields, " kind"};
    if (r.payload_byte !== want.payload_byte)     bad_fields = {bad_fields, " payload_byte"};
    if (r.byte_index !== want.byte_index)         bad_fields = {bad_fields, " byte_index"};
    if (r.version_bit !== want.version_bit)       bad_fields = {bad_fields, " version_bit"};
    if (r.flag_bits !== want.flag_bits)           bad_fields = {bad_fields, " flag_bits"};
    if (r.frame_id !== want.frame_id)             bad_fields = {bad_fields, " frame_id"};
    if (r.payload_length !== want.payload_length) bad_fields = {bad_fields, " payload_length"};
    if (r.received_crc !== want.received_crc)     bad_fields = {bad_fields, " received_crc"};
    if (r.crc_ok !== want.crc_ok)                 bad_fields = {bad_fields, " crc_ok"};
    if (r.last !== want.last)                     bad_fields = {bad_fields, " last"};
    if (bad_fields != "") begin
      error_count++;
      if (shown < 10) begin
        shown++;
        $display("%0t: mismatch in%s", $realtime, bad_fields);
        $write("  exp kind=%0d byte=%02h idx=%0d ver=%0d flags=%02h",
               want.kind, want.payload_byte, want.byte_index, want.version_bit,
               want.flag_bits);
        $display(" id=%02h len=%0d crc=%04h ok=%0d last=%0d",
                 want.frame_id, want.payload_length, want.received_crc, want.crc_ok,
                 want.last);
        $write("  got kind=%0d byte=%02h idx=%0d ver=%0d flags=%02h",
               r.kind, r.payload_byte, r.byte_index, r.version_bit, r.flag_bits);
        $display(" id=%02h len=%0d crc=%04h ok=%0d last=%0d",
                 r.frame_id, r.payload_length, r.received_crc, r.crc_ok, r.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      decoded_results.delete();
      error_count = 0;
    end else begin
      // a result never leaves in the cycle its byte arrives, so outputs go first
      if (m_axis_tvalid && m_axis_tready) begin
        got                = '0;
        got.kind           = m_axis_tuser;
        got.payload_byte   = m_axis_tdata[7:0];
        got.byte_index     = m_axis_tdata[15:8];
        got.version_bit    = m_axis_tdata[16];
        got.flag_bits      = m_axis_tdata[23:17];
        got.frame_id       = m_axis_tdata[31:24];
        got.payload_length = m_axis_tdata[39:32];
        got.received_crc   = m_axis_tdata[55:40];
        got.crc_ok         = m_axis_tdata[56];
        got.last           = m_axis_tlast;
        check_transfer(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata, has_res, next_res);
        if (has_res) begin
          decoded_results = {decoded_results, next_res};
        end
      end
    end
    results_owed = decoded_results.size();
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives framed byte streams into the crc-16/arc frame decoder: a few directed
// frames covering field extremes, empty payloads and good and bad crcs, then
// random frames with random content, corrupted crcs and noise bursts followed
// by resync filler. Both sides idle at random; the receiver also holds off for
// one long stretch and the sender pauses for a full drain now and then.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 400;

  localparam int CRC_GOOD   = 0;
  localparam int CRC_RANDOM = 1;
  localparam int CRC_FLIP   = 2;
  localparam int CRC_ONES   = 3;

  typedef logic [7:0] bytes_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int error_count;
  int results_owed;

  bit hold_req   = 1'b0;
  bit gapless    = 1'b0;
  int items_sent = 0;
  int idle_cycles;

  // framing position of the stream as sent, used to realign after noise
  pfd_pkg::phase_t trk_phase = pfd_pkg::PH_HDR0;
  int              trk_left  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  packet_frame_decoder_crc16 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pfd_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .error_count   (error_count),
    .results_owed  (results_owed)
  );

  function automatic logic [15:0] frame_crc(input bytes_t body);
    logic [15:0] c;
    c = 16'h0000;
    foreach (body[i]) begin
      c = c ^ {8'h00, body[i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ pfd_pkg::CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
    case (trk_phase)
      pfd_pkg::PH_HDR0: trk_phase = pfd_pkg::PH_HDR1;
      pfd_pkg::PH_HDR1: trk_phase = pfd_pkg::PH_HDR2;
      pfd_pkg::PH_HDR2: begin
        trk_left  = int'(b);
        trk_phase = (b == 8'h00) ? pfd_pkg::PH_CRCLO : pfd_pkg::PH_PAYLOAD;
      end
      pfd_pkg::PH_PAYLOAD: begin
        trk_left--;
        if (trk_left == 0) trk_phase = pfd_pkg::PH_CRCLO;
      end
      pfd_pkg::PH_CRCLO: trk_phase = pfd_pkg::PH_CRCHI;
      default: trk_phase = pfd_pkg::PH_HDR0;
    endcase
  endtask

  task automatic send_frame(input bytes_t body, input int crc_mode);
    logic [15:0] crc;
    crc = frame_crc(body);
    case (crc_mode)
      CRC_RANDOM: crc = 16'($urandom_range(0, 65535));
      CRC_FLIP:   crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      CRC_ONES:   crc = 16'hFFFF;
      default:    crc = crc;
    endcase
    body = {body, crc[7:0], crc[15:8]};
    foreach (body[i]) send_byte(body[i]);
  endtask

  task automatic send_random_frame(input int len);
    bytes_t body;
    int     r;
    body = {body, 8'($urandom_range(0, 255))};
    body = {body, 8'($urandom_range(0, 255))};
    body = {body, len[7:0]};
    repeat (len) body = {body, 8'($urandom_range(0, 255))};
    r = $urandom_range(0, 99);
    send_frame(body, (r < 70) ? CRC_GOOD : (r < 85) ? CRC_RANDOM : CRC_FLIP);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  // receiver: random ready runs and stalls, plus one long hold on request
  initial begin
    int run_cnt;
    int stall_cnt;
    int r;
    bit hold_taken;
    run_cnt    = 0;
    stall_cnt  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        run_cnt    = 0;
        stall_cnt  = HOLD_CYCLES;
      end
      if (run_cnt == 0 && stall_cnt == 0) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          run_cnt = $urandom_range(50, 150);
        end else begin
          run_cnt = $urandom_range(1, 12);
          r = $urandom_range(0, 99);
          stall_cnt = (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
      end
      if (run_cnt > 0) begin
        m_axis_tready <= 1'b1;
        run_cnt--;
      end else begin
        m_axis_tready <= 1'b0;
        stall_cnt--;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int frame_no;
    int len;
    int r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames
    send_frame('{8'h00, 8'h00, 8'h00}, CRC_GOOD);
    send_frame('{8'hFF, 8'hFF, 8'h02, 8'hFF, 8'h00}, CRC_ONES);
    send_frame('{8'h80, 8'h5A, 8'h01, 8'hA5}, CRC_GOOD);
    send_frame('{8'h7F, 8'h01, 8'h03, 8'h00, 8'h80, 8'h01}, CRC_FLIP);
    drain_results();

    frame_no = 0;
    while (items_sent < ITEM_TARGET) begin
      frame_no++;
      gapless = ($urandom_range(0, 3) == 0);
      if (frame_no % 45 == 0) drain_results();
      r = $urandom_range(0, 99);
      if (frame_no == 1) begin
        len = 255;
      end else if (frame_no == 15) begin
        // receiver stops for a long stretch while bytes keep coming
        hold_req = 1'b1;
        gapless  = 1'b1;
        len      = 24;
      end else if (r < 10) begin
        // noise burst, then filler until the stream is back on a frame boundary
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        while (trk_phase != pfd_pkg::PH_HDR0) begin
          send_byte((trk_phase == pfd_pkg::PH_HDR2) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        continue;
      end else if (r < 14) begin
        len = $urandom_range(128, 255);
      end else if (r < 28) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 12);
      end
      send_random_frame(len);
    end

    gapless = 1'b0;
    drain_results();
    repeat (8) @(negedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: packet_frame_decoder_crc16.f
rtl/pfd_pkg.sv
rtl/pfd_parser.sv
rtl/pfd_out_reg.sv
rtl/packet_frame_decoder_crc16.sv
sim/pfd_checker.sv
sim/tb_top.sv
